@@ hdl/tssm_pkg.sv @@
// Package for the two-stack shared memory block.
// Holds sizes, operation and status codes, and the word types of both channels.
// Depends on nothing.
package tssm_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_LEFT  = 2'd0,
    KIND_PUSH_RIGHT = 2'd1,
    KIND_POP_LEFT   = 2'd2,
    KIND_POP_RIGHT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [DW-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [DW-1:0] left_top;
    logic signed [DW-1:0] right_top;
    logic                 left_empty;
    logic                 right_empty;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

@@ hdl/tssm_ctrl.sv @@
// Sequencer for the two-stack shared memory block.
// Steps each word through capture, update, memory read and result load.
// Depends on tssm_pkg.
module tssm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tssm_pkg::stat_t stat,
  output tssm_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/tssm_datapath.sv @@
// Datapath for the two-stack shared memory block.
// Holds the shared store, both stack counts and the result register.
// Depends on tssm_pkg.
module tssm_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tssm_pkg::cmd_t      cmd,
  output tssm_pkg::stat_t     stat,
  input  tssm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tssm_pkg::out_word_t out_data
);

  logic [tssm_pkg::DW-1:0] mem [tssm_pkg::DEPTH];

  logic [1:0]              kind_r;
  logic [tssm_pkg::DW-1:0] value_r;
  logic [tssm_pkg::CW-1:0] left_count_r, left_count_nxt;
  logic [tssm_pkg::CW-1:0] right_count_r, right_count_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [tssm_pkg::DW-1:0] rd_left_r, rd_right_r;
  logic                    out_valid_r;
  tssm_pkg::out_word_t     out_data_r;

  logic                    full;
  logic                    wr_en;
  logic [tssm_pkg::AW-1:0] wr_addr;
  logic [tssm_pkg::AW-1:0] left_addr, right_addr;
  logic                    left_zero, right_zero;

  assign full = ({1'b0, left_count_r} + {1'b0, right_count_r}) >=
                (tssm_pkg::CW + 1)'(tssm_pkg::DEPTH);

  assign left_zero  = (left_count_r == '0);
  assign right_zero = (right_count_r == '0);
  assign left_addr  = tssm_pkg::AW'(left_count_r - 1'b1);
  assign right_addr = tssm_pkg::AW'(tssm_pkg::CW'(tssm_pkg::DEPTH) - right_count_r);

  always_comb begin
    left_count_nxt  = left_count_r;
    right_count_nxt = right_count_r;
    status_nxt      = tssm_pkg::ST_DONE;
    wr_en           = 1'b0;
    wr_addr         = tssm_pkg::AW'(left_count_r);
    case (kind_r)
      tssm_pkg::KIND_PUSH_LEFT: begin
        if (full) begin
          status_nxt = tssm_pkg::ST_OVERFLOW;
        end else begin
          wr_en          = 1'b1;
          left_count_nxt = left_count_r + 1'b1;
        end
      end
      tssm_pkg::KIND_PUSH_RIGHT: begin
        wr_addr = tssm_pkg::AW'(tssm_pkg::CW'(tssm_pkg::DEPTH - 1) - right_count_r);
        if (full) begin
          status_nxt = tssm_pkg::ST_OVERFLOW;
        end else begin
          wr_en           = 1'b1;
          right_count_nxt = right_count_r + 1'b1;
        end
      end
      tssm_pkg::KIND_POP_LEFT: begin
        if (left_zero) begin
          status_nxt = tssm_pkg::ST_UNDERFLOW;
        end else begin
          left_count_nxt = left_count_r - 1'b1;
        end
      end
      default: begin
        if (right_zero) begin
          status_nxt = tssm_pkg::ST_UNDERFLOW;
        end else begin
          right_count_nxt = right_count_r - 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value_r;
    end
    if (cmd.read) begin
      rd_left_r  <= mem[left_addr];
      rd_right_r <= mem[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_data.kind;
      value_r <= in_data.push_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
    if (cmd.load_out) begin
      out_data_r.status      <= status_r;
      out_data_r.left_top    <= left_zero ? '1 : $signed(rd_left_r);
      out_data_r.right_top   <= right_zero ? '1 : $signed(rd_right_r);
      out_data_r.left_empty  <= left_zero;
      out_data_r.right_empty <= right_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_count_r  <= '0;
      right_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        left_count_r  <= left_count_nxt;
        right_count_r <= right_count_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

@@ hdl/two_stacks_shared_memory_top.sv @@
// Two stacks in one shared memory: the left grows up, the right grows down.
// A result word is registered after capture, update, read and load; the load
// waits while the output is stalled. A new word is taken only after that load,
// as the steps share the single store and result register.
// Reset (rst_n low, synchronous) empties both stacks; store contents are kept.
module two_stacks_shared_memory_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tssm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tssm_pkg::out_word_t out_data
);

  tssm_pkg::cmd_t  cmd;
  tssm_pkg::stat_t stat;

  tssm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tssm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/tssm_checker.sv @@
// Port-level checks for the two-stack shared memory block, and their bind.
// Depends on tssm_pkg and two_stacks_shared_memory_top.
module tssm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tssm_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result word changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken while a word is in progress.");

  a_left_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.left_empty |-> out_data.left_top == -32'sd1)
    else $error("Empty left stack shows a top word.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("Result word carries an unknown status.");

endmodule

bind two_stacks_shared_memory_top tssm_checker u_tssm_checker (.*);
